/* rtl/tcw_pkg.sv */
package tcw_pkg;

  // Width of the running column counter (8 to 32).
  localparam int COUNT_BITS = 16;
  localparam int WIDTH_BITS = 16;
  localparam int CP_BITS    = 21;

  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] ESC_END_M  = 8'h6D;  // 'm'
  localparam logic [7:0] ESC_END_J  = 8'h4A;  // 'J'
  localparam logic [7:0] LEAD_MIN   = 8'h80;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [5:0] CONT_MASK  = 6'h3F;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [CP_BITS-1:0]    cp_t;

  typedef struct packed {
    logic       in_escape;
    logic [1:0] bytes_pending;
    cp_t        code_point;
    count_t     width_count;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '0;

  // Wide (two-column) code point ranges: emoji, Hangul jamo, CJK, fullwidth.
  function automatic logic is_wide(input cp_t cp);
    logic wide;
    wide = cp inside {[21'h1F000:21'h1F9FF], [21'h01100:21'h0115F],
                      [21'h02E80:21'h0303E], [21'h03041:21'h033BF],
                      [21'h0FF01:21'h0FF60]};
    return wide;
  endfunction

  // Clamp the counter to the result field.
  function automatic logic [WIDTH_BITS-1:0] clamp_width(input count_t c);
    logic [31:0] wide;
    wide = 32'(c);
    return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[WIDTH_BITS-1:0];
  endfunction

endpackage

/* rtl/tcw_step.sv */
module tcw_step (
  input  tcw_pkg::scan_state_t  state,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_string,
  output tcw_pkg::scan_state_t  state_next,
  output logic [tcw_pkg::WIDTH_BITS-1:0] column_width
);

  tcw_pkg::scan_state_t s1;
  tcw_pkg::cp_t         cp_fill;
  logic [1:0]           add_cols;
  logic [tcw_pkg::COUNT_BITS:0] sum;
  tcw_pkg::count_t      count_new;

  // Byte decode; at most one character completes per byte.
  always_comb begin
    s1       = state;
    add_cols = 2'd0;
    cp_fill  = '0;
    if (state.bytes_pending != 2'd0) begin
      s1.code_point    = {state.code_point[tcw_pkg::CP_BITS-7:0],
                          text_byte[5:0] & tcw_pkg::CONT_MASK};
      s1.bytes_pending = state.bytes_pending - 2'd1;
      if (s1.bytes_pending == 2'd0) begin
        add_cols = tcw_pkg::is_wide(s1.code_point) ? 2'd2 : 2'd1;
      end
    end else if (text_byte == tcw_pkg::ESC_BYTE) begin
      s1.in_escape = 1'b1;
    end else if (state.in_escape) begin
      if (text_byte == tcw_pkg::ESC_END_M || text_byte == tcw_pkg::ESC_END_J) begin
        s1.in_escape = 1'b0;
      end
    end else if (text_byte >= tcw_pkg::LEAD_MIN) begin
      if (text_byte < tcw_pkg::LEAD3_MIN) begin
        s1.code_point    = tcw_pkg::cp_t'(text_byte[4:0]);
        s1.bytes_pending = 2'd1;
      end else if (text_byte < tcw_pkg::LEAD4_MIN) begin
        s1.code_point    = tcw_pkg::cp_t'(text_byte[3:0]);
        s1.bytes_pending = 2'd2;
      end else begin
        s1.code_point    = tcw_pkg::cp_t'(text_byte[2:0]);
        s1.bytes_pending = 2'd3;
      end
    end else begin
      add_cols = 2'd1;
    end

    // Truncated sequence at end of string: missing groups are zero.
    if (end_of_string && s1.bytes_pending != 2'd0) begin
      case (s1.bytes_pending)
        2'd1:    cp_fill = {s1.code_point[tcw_pkg::CP_BITS-7:0], 6'd0};
        2'd2:    cp_fill = {s1.code_point[tcw_pkg::CP_BITS-13:0], 12'd0};
        2'd3:    cp_fill = {s1.code_point[tcw_pkg::CP_BITS-19:0], 18'd0};
        default: cp_fill = s1.code_point;
      endcase
      add_cols = tcw_pkg::is_wide(cp_fill) ? 2'd2 : 2'd1;
    end
  end

  // Saturating count update.
  always_comb begin
    sum       = {1'b0, state.width_count} + (tcw_pkg::COUNT_BITS+1)'(add_cols);
    count_new = sum[tcw_pkg::COUNT_BITS] ? '1 : sum[tcw_pkg::COUNT_BITS-1:0];
    column_width = tcw_pkg::clamp_width(count_new);
    if (end_of_string) begin
      state_next = tcw_pkg::SCAN_RESET;
    end else begin
      state_next             = s1;
      state_next.width_count = count_new;
    end
  end

endmodule

/* rtl/terminal_column_width.sv */
// Terminal column width of a byte string.
//
// Text channel: one byte per transfer (text_byte, end_of_string), with
// text_valid / text_stall. end_of_string marks the last byte of a string.
// Width channel: one column_width per string, with width_valid / width_stall,
// sent for the transfer that carries end_of_string. Escape sequences
// (0x1B up to 'm' or 'J') are skipped; UTF-8 wide ranges count two columns.
//
// Timing: a byte is registered at the input, decoded from that register and
// the result lands in the output register: width_valid rises when the final
// byte moves on from the input register. Throughput: one byte per cycle while
// no final byte waits on a stalled result, set by the combinational
// decode/count update of the scan state.
// Stall: a pending result holds in the output register; only a final byte
// waits behind it, ordinary bytes keep flowing. The text side stalls only
// while the input register holds a final byte that cannot move.
// Reset: rst (sync, active high) empties both registers and clears the scan
// state; after each result the state returns to reset on its own.
module terminal_column_width (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        end_of_string,
  output logic        width_valid,
  input  logic        width_stall,
  output logic [tcw_pkg::WIDTH_BITS-1:0] column_width
);

  // Input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_eos;

  tcw_pkg::scan_state_t state;
  tcw_pkg::scan_state_t state_next;
  logic [tcw_pkg::WIDTH_BITS-1:0] width_next;

  logic advance;
  logic load_result;
  logic out_free;

  assign out_free    = !width_valid || !width_stall;
  assign advance     = hold_valid && (!hold_eos || out_free);
  assign load_result = advance && hold_eos;
  assign text_stall  = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!text_stall) begin
      hold_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      hold_byte <= text_byte;
      hold_eos  <= end_of_string;
    end
  end

  tcw_step u_step (
    .state        (state),
    .text_byte    (hold_byte),
    .end_of_string(hold_eos),
    .state_next   (state_next),
    .column_width (width_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::SCAN_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      width_valid <= 1'b0;
    end else if (load_result) begin
      width_valid <= 1'b1;
    end else if (!width_stall) begin
      width_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      column_width <= width_next;
    end
  end

  // Assertions
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> hold_valid && hold_eos)
    else $error("text stalled without a blocked final byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_result |-> !width_valid || !width_stall)
    else $error("result register overwritten while stalled");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    load_result |=> state.width_count == '0 && state.bytes_pending == 2'd0 &&
                    !state.in_escape)
    else $error("scan state not cleared after end of string");

  a_escape_no_pending: assert property (@(posedge clk) disable iff (rst)
    state.in_escape |-> state.bytes_pending == 2'd0)
    else $error("escape open with continuation bytes pending");

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Limit on cycles in a row with no transfer on either channel.
  localparam int STALL_LIMIT = 5000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  // Text channel, driven by the sender task.
  logic       text_valid    = 1'b0;
  logic       text_stall;
  logic [7:0] text_byte     = 8'h00;
  logic       end_of_string = 1'b0;

  // Width channel; width_stall is driven by the random stall process.
  logic                            width_valid;
  logic                            width_stall = 1'b0;
  logic [tcw_pkg::WIDTH_BITS-1:0]  column_width;

  // Idle and stall rates (percent of cycles), set per phase.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int mismatch_count = 0;
  int quiet_cycles   = 0;

  // Widths still owed by the block, oldest first.
  logic [tcw_pkg::WIDTH_BITS-1:0] width_due[$];
  logic [tcw_pkg::WIDTH_BITS-1:0] due_width;

  // Bytes of the string being built, sent with end_of_string on the last one.
  logic [7:0] string_bytes[$];

  // Scan state of the width predictor, mirrors what the block keeps.
  logic                          scan_escape  = 1'b0;
  logic [1:0]                    scan_pending = 2'd0;
  logic [20:0]                   scan_code    = 21'd0;
  logic [tcw_pkg::COUNT_BITS-1:0] scan_columns = '0;

  terminal_column_width u_top (
    .clk           (clk),
    .rst           (rst),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .text_byte     (text_byte),
    .end_of_string (end_of_string),
    .width_valid   (width_valid),
    .width_stall   (width_stall),
    .column_width  (column_width)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Width predictor
  // ---------------------------------------------------------------------

  // Wide ranges: emoji, Hangul jamo, CJK punctuation/radicals, kana and
  // CJK compatibility, fullwidth forms.
  function automatic int char_columns(input logic [20:0] cp);
    if ((cp >= 21'h1F000 && cp <= 21'h1F9FF) ||
        (cp >= 21'h01100 && cp <= 21'h0115F) ||
        (cp >= 21'h02E80 && cp <= 21'h0303E) ||
        (cp >= 21'h03041 && cp <= 21'h033BF) ||
        (cp >= 21'h0FF01 && cp <= 21'h0FF60))
      return 2;
    return 1;
  endfunction

  // Saturating add into the running count.
  task automatic add_columns(input int n);
    longint unsigned top;
    longint unsigned total;
    top   = (64'd1 << tcw_pkg::COUNT_BITS) - 64'd1;
    total = 64'(scan_columns) + 64'(n);
    scan_columns = (total > top) ? '1 : total[tcw_pkg::COUNT_BITS-1:0];
  endtask

  // One byte through the scan; done is set when a width comes out.
  task automatic scan_byte(input logic [7:0] b, input logic last,
                           output logic done,
                           output logic [tcw_pkg::WIDTH_BITS-1:0] width);
    longint unsigned count;
    done  = 1'b0;
    width = '0;
    if (scan_pending != 2'd0) begin
      // Any byte, even ESC, is taken as a continuation here.
      scan_code    = {scan_code[14:0], b[5:0]};
      scan_pending = scan_pending - 2'd1;
      if (scan_pending == 2'd0) add_columns(char_columns(scan_code));
    end else if (b == tcw_pkg::ESC_BYTE) begin
      scan_escape = 1'b1;
    end else if (scan_escape) begin
      if (b == tcw_pkg::ESC_END_M || b == tcw_pkg::ESC_END_J) scan_escape = 1'b0;
    end else if (b >= 8'h80) begin
      // Stray continuation bytes decode as two-byte leads.
      if (b < 8'hE0) begin
        scan_code    = 21'(b[4:0]);
        scan_pending = 2'd1;
      end else if (b < 8'hF0) begin
        scan_code    = 21'(b[3:0]);
        scan_pending = 2'd2;
      end else begin
        scan_code    = 21'(b[2:0]);
        scan_pending = 2'd3;
      end
    end else begin
      add_columns(1);
    end
    if (last) begin
      // Truncated sequence: missing groups read as zero.
      if (scan_pending != 2'd0) begin
        scan_code = scan_code << (6 * scan_pending);
        add_columns(char_columns(scan_code));
      end
      count = 64'(scan_columns);
      width = (count > 64'hFFFF) ? 16'hFFFF : count[15:0];
      done  = 1'b1;
      scan_escape  = 1'b0;
      scan_pending = 2'd0;
      scan_code    = '0;
      scan_columns = '0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------

  // Drive one byte, hold it until the transfer, then log the expected width.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int                             gap;
    logic                           has_width;
    logic [tcw_pkg::WIDTH_BITS-1:0] width;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct && gap < 200)
      gap++;
    if (gap != 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid    <= 1'b1;
    text_byte     <= b;
    end_of_string <= last;
    do @(posedge clk); while (text_stall);
    scan_byte(b, last, has_width, width);
    if (has_width) width_due.push_back(width);
  endtask

  // Send string_bytes as one string and empty it.
  task automatic send_string;
    foreach (string_bytes[i]) send_byte(string_bytes[i], i == string_bytes.size() - 1);
    string_bytes.delete();
  endtask

  // Sender goes quiet until every owed width has come back.
  task automatic wait_for_results;
    text_valid <= 1'b0;
    do @(posedge clk); while (width_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Random string building
  // ---------------------------------------------------------------------

  // Code point biased toward the edges of the wide ranges.
  function automatic logic [20:0] pick_code();
    logic [20:0] lo[5];
    logic [20:0] hi[5];
    int          k;
    int          r;
    lo = '{21'h1F000, 21'h01100, 21'h02E80, 21'h03041, 21'h0FF01};
    hi = '{21'h1F9FF, 21'h0115F, 21'h0303E, 21'h033BF, 21'h0FF60};
    k  = $urandom_range(0, 4);
    r  = $urandom_range(0, 9);
    if (r < 2) return lo[k] - 21'($urandom_range(0, 1));
    if (r < 4) return hi[k] + 21'($urandom_range(0, 1));
    if (r < 7) return 21'($urandom_range(lo[k], hi[k]));
    if (r < 8) return 21'($urandom_range(0, 21'h7FF));
    if (r < 9) return 21'($urandom_range(0, 21'hFFFF));
    return 21'($urandom_range(0, 21'h1FFFFF));
  endfunction

  // Continuation byte; now and then with a wrong marker.
  function automatic logic [7:0] cont_byte(input logic [5:0] bits);
    logic [1:0] top;
    top = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
    return {top, bits};
  endfunction

  // UTF-8 for cp, shortest form or overlong, cut to at most keep bytes.
  task automatic push_utf8(input logic [20:0] cp, input int keep);
    logic [7:0] seq[$];
    int         len;
    len = (cp >= 21'h10000) ? 4 : (cp >= 21'h800) ? 3 : 2;
    if (len < 4 && $urandom_range(0, 7) == 0) len = $urandom_range(len + 1, 4);
    case (len)
      2: seq = '{8'hC0 | 8'(cp[10:6]), cont_byte(cp[5:0])};
      3: seq = '{8'hE0 | 8'(cp[15:12]), cont_byte(cp[11:6]), cont_byte(cp[5:0])};
      default: seq = '{8'hF0 | 8'(cp[20:18]), cont_byte(cp[17:12]),
                       cont_byte(cp[11:6]), cont_byte(cp[5:0])};
    endcase
    foreach (seq[i]) if (i < keep) string_bytes.push_back(seq[i]);
  endtask

  // Escape sequence with a random body, closed by 'm' or 'J'.
  task automatic push_escape;
    int n;
    string_bytes.push_back(tcw_pkg::ESC_BYTE);
    if ($urandom_range(0, 3) != 0) string_bytes.push_back(8'h5B);
    n = $urandom_range(0, 4);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) string_bytes.push_back(8'($urandom_range(0, 255)));
      else string_bytes.push_back(($urandom_range(0, 5) == 0) ? 8'h3B :
                                  8'($urandom_range(8'h30, 8'h39)));
    end
    string_bytes.push_back($urandom_range(0, 1) ? tcw_pkg::ESC_END_M : tcw_pkg::ESC_END_J);
  endtask

  // One random string: mostly well-formed text, escapes and UTF-8, with
  // stray lead bytes, raw noise and the odd cut-off tail.
  task automatic build_string;
    int tokens;
    int r;
    tokens = $urandom_range(1, 8);
    repeat (tokens) begin
      r = $urandom_range(0, 99);
      if (r < 35)      string_bytes.push_back(8'($urandom_range(0, 127)));
      else if (r < 65) push_utf8(pick_code(), 4);
      else if (r < 80) push_escape();
      else if (r < 90) string_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
      else             string_bytes.push_back(8'($urandom_range(0, 255)));
    end
    // End inside a multi-byte sequence now and then.
    if ($urandom_range(0, 5) == 0) push_utf8(pick_code(), $urandom_range(1, 3));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Short hand-picked strings: byte extremes, escapes, wide forms, strays,
  // ESC as a continuation, truncation and a string that ends in an escape.
  task automatic test_directed;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Byte zero is a plain character.
    string_bytes = '{8'h00};
    send_string();
    // 0x7F, a full escape, then a 0xFF lead cut short.
    string_bytes = '{8'h7F, 8'h1B, 8'h5B, 8'h6D, 8'hFF};
    send_string();
    // ESC inside an escape, closed by 'J', then a kana character.
    string_bytes = '{8'h1B, 8'h1B, 8'h4A, 8'hE3, 8'h81, 8'h82};
    send_string();
    // Emoji, then a stray 0x80 lead that swallows an ESC.
    string_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'h1B};
    send_string();
    // Fullwidth form, then an emoji lead cut after two bytes.
    string_bytes = '{8'hEF, 8'hBC, 8'h81, 8'hF0, 8'h9F};
    send_string();
    // String ending inside an escape; the next one starts clean.
    string_bytes = '{8'h1B};
    send_string();
    string_bytes = '{8'h6D};
    send_string();
    wait_for_results();
  endtask

  // Random strings under one idle/stall setting.
  task automatic test_random(input int items, input int idle_pct, input int stall_pct);
    int sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      build_string();
      sent += string_bytes.size();
      send_string();
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    width_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Every width transfer is matched against the oldest owed width.
  always @(posedge clk) begin
    if (!rst && width_valid && !width_stall) begin
      if (width_due.size() == 0) begin
        $display("%0t: column_width expected none, got %0d", $time, column_width);
        mismatch_count++;
      end else begin
        due_width = width_due.pop_front();
        if (column_width !== due_width) begin
          $display("%0t: column_width expected %0d, got %0d",
                   $time, due_width, column_width);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (width_valid && !width_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(250, 0, 0);
    test_random(250, 84, 0);
    test_random(250, 0, 84);
    test_random(250, 24, 24);

    // Drain, then give a stray extra width time to show up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* terminal_column_width.f */
rtl/tcw_pkg.sv
rtl/tcw_step.sv
rtl/terminal_column_width.sv
bench/testbench.sv
